// ===== rtl/source_tokenizer_macros.svh =====
// Assertion macros used by the tokenizer checker.
`ifndef SOURCE_TOKENIZER_MACROS_SVH
`define SOURCE_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/st_pkg.sv =====
package st_pkg;

    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int POSITION_BITS_DEF = 16;
    localparam int OFFSET_BITS_DEF   = 32;

    localparam int FIFO_DEPTH = 4;

    localparam int KW_COUNT   = 22;
    localparam int KW_MAX_LEN = 8;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef struct packed {
        logic       mode;
        logic [7:0] char_byte;
    } char_req_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] first_line;
        logic [15:0] first_column;
        logic [31:0] start_offset;
        logic [15:0] text_length;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } st_push_t;

    localparam logic [5:0] K_IDENT       = 6'd0;
    localparam logic [5:0] K_NUMBER      = 6'd23;
    localparam logic [5:0] K_STRING      = 6'd24;
    localparam logic [5:0] K_EQEQ        = 6'd25;
    localparam logic [5:0] K_ASSIGN      = 6'd26;
    localparam logic [5:0] K_PLUS        = 6'd27;
    localparam logic [5:0] K_MINUS       = 6'd28;
    localparam logic [5:0] K_STAR        = 6'd29;
    localparam logic [5:0] K_SLASH       = 6'd30;
    localparam logic [5:0] K_NE          = 6'd31;
    localparam logic [5:0] K_BANG        = 6'd32;
    localparam logic [5:0] K_LE          = 6'd33;
    localparam logic [5:0] K_LT          = 6'd34;
    localparam logic [5:0] K_GE          = 6'd35;
    localparam logic [5:0] K_GT          = 6'd36;
    localparam logic [5:0] K_ANDAND      = 6'd37;
    localparam logic [5:0] K_OROR        = 6'd38;
    localparam logic [5:0] K_LPAREN      = 6'd39;
    localparam logic [5:0] K_RPAREN      = 6'd40;
    localparam logic [5:0] K_LBRACE      = 6'd41;
    localparam logic [5:0] K_RBRACE      = 6'd42;
    localparam logic [5:0] K_SEMI        = 6'd43;
    localparam logic [5:0] K_COMMA       = 6'd44;
    localparam logic [5:0] K_UNKNOWN     = 6'd45;
    localparam logic [5:0] K_END         = 6'd46;
    localparam logic [5:0] K_OPEN_STRING = 6'd47;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Right-justified keyword text; kind is index plus one.
    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "let", "there", "be", "of", "blessed", "function", "if", "else",
        "for", "while", "sacred", "divine", "pray", "forgive", "int", "float",
        "string", "bool", "true", "false", "return", "print"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd2, 4'd2, 4'd7, 4'd8, 4'd2, 4'd4, 4'd3, 4'd5, 4'd6,
        4'd6, 4'd4, 4'd7, 4'd3, 4'd5, 4'd6, 4'd4, 4'd4, 4'd5, 4'd6, 4'd5
    };

endpackage

// ===== rtl/st_lexer.sv =====
module st_lexer
    import st_pkg::*;
#(
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_valid,
    input  char_req_t step,
    output st_push_t  push
);

    localparam int IDX_BITS = $clog2(KEYWORD_CHARS);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [OFFSET_BITS-1:0]   OFF_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    typedef enum logic [3:0] {
        OT_IDLE, OT_IDENT, OT_NUMBER, OT_STRING, OT_EQ,
        OT_BANG, OT_LT, OT_GT, OT_AMP, OT_BAR
    } open_t;

    open_t                    open_reg, open_next;
    logic                     overlong_reg, overlong_next;
    logic [15:0]              count_reg, count_next;
    logic [POSITION_BITS-1:0] tok_line_reg, tok_line_next;
    logic [POSITION_BITS-1:0] tok_col_reg, tok_col_next;
    logic [OFFSET_BITS-1:0]   tok_off_reg, tok_off_next;
    logic [POSITION_BITS-1:0] cur_line_reg, cur_line_next;
    logic [POSITION_BITS-1:0] cur_col_reg, cur_col_next;
    logic [OFFSET_BITS-1:0]   cur_off_reg, cur_off_next;
    logic [7:0]               word_reg [KEYWORD_CHARS];

    logic                store_we;
    logic [IDX_BITS-1:0] store_idx;

    logic [7:0]  c;
    logic        is_space, is_digit, is_alpha, ident_cont;
    logic [15:0] count_inc;
    logic [5:0]  kw_kind;
    logic        flush_valid;
    logic [5:0]  flush_kind;
    logic [15:0] flush_len;
    logic        consumed;
    logic        r0_valid, r1_valid;
    logic [5:0]  r0_kind, r1_kind;
    logic [15:0] r0_len, r1_len;
    token_t      r0, r1;

    assign c          = step.char_byte;
    assign is_space   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign is_digit   = (c >= CH_0) && (c <= CH_9);
    assign is_alpha   = (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    assign ident_cont = is_alpha || is_digit || (c == CH_UNDER);
    assign count_inc  = (count_reg != LEN_MAX) ? count_reg + 16'd1 : count_reg;

    always_comb
    begin
        logic [KW_MAX_LEN*8-1:0] kw;
        logic                    hit;
        kw_kind = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            kw  = KW_TEXT[i] << (8 * (KW_MAX_LEN - int'(KW_LEN[i])));
            hit = (count_reg == 16'(KW_LEN[i])) && !overlong_reg;
            for (int j = 0; j < KW_MAX_LEN; j++)
            begin
                if (j < int'(KW_LEN[i]) && word_reg[j] != kw[KW_MAX_LEN*8-1-8*j -: 8])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                kw_kind = 6'(i + 1);
            end
        end
    end

    always_comb
    begin
        flush_valid = 1'b1;
        flush_kind  = K_UNKNOWN;
        flush_len   = 16'd1;
        case (open_reg)
            OT_IDENT:
            begin
                flush_kind = kw_kind;
                flush_len  = count_reg;
            end
            OT_NUMBER:
            begin
                flush_kind = K_NUMBER;
                flush_len  = count_reg;
            end
            OT_EQ:   flush_kind = K_ASSIGN;
            OT_BANG: flush_kind = K_BANG;
            OT_LT:   flush_kind = K_LT;
            OT_GT:   flush_kind = K_GT;
            OT_AMP:  flush_kind = K_UNKNOWN;
            OT_BAR:  flush_kind = K_UNKNOWN;
            default: flush_valid = 1'b0;
        endcase
    end

    always_comb
    begin
        open_next     = open_reg;
        overlong_next = overlong_reg;
        count_next    = count_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        tok_off_next  = tok_off_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        cur_off_next  = cur_off_reg;
        store_we      = 1'b0;
        store_idx     = count_reg[IDX_BITS-1:0];
        consumed      = 1'b0;
        r0_valid      = 1'b0;
        r0_kind       = K_IDENT;
        r0_len        = 16'd0;
        r1_valid      = 1'b0;
        r1_kind       = K_UNKNOWN;
        r1_len        = 16'd1;

        if (step.mode)
        begin
            if (open_reg == OT_STRING)
            begin
                r0_valid = 1'b1;
                r0_kind  = K_OPEN_STRING;
                r0_len   = count_reg;
            end
            else
            begin
                r0_valid = flush_valid;
                r0_kind  = flush_kind;
                r0_len   = flush_len;
                r1_valid = 1'b1;
                r1_kind  = K_END;
                r1_len   = 16'd0;
            end
            open_next     = OT_IDLE;
            overlong_next = 1'b0;
            count_next    = 16'd0;
            tok_line_next = POS_ONE;
            tok_col_next  = POS_ONE;
            tok_off_next  = '0;
            cur_line_next = POS_ONE;
            cur_col_next  = POS_ONE;
            cur_off_next  = '0;
        end
        else
        begin
            case (open_reg)
                OT_IDENT:
                begin
                    if (ident_cont)
                    begin
                        consumed = 1'b1;
                        if (count_reg < 16'(KEYWORD_CHARS))
                        begin
                            store_we = 1'b1;
                        end
                        else
                        begin
                            overlong_next = 1'b1;
                        end
                        count_next = count_inc;
                    end
                end
                OT_NUMBER:
                begin
                    if (is_digit || c == CH_DOT)
                    begin
                        consumed   = 1'b1;
                        count_next = count_inc;
                    end
                end
                OT_STRING:
                begin
                    consumed = 1'b1;
                    if (c == CH_QUOTE)
                    begin
                        r0_valid  = 1'b1;
                        r0_kind   = K_STRING;
                        r0_len    = count_reg;
                        open_next = OT_IDLE;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                OT_EQ, OT_BANG, OT_LT, OT_GT:
                begin
                    if (c == CH_EQ)
                    begin
                        consumed  = 1'b1;
                        r0_valid  = 1'b1;
                        r0_len    = 16'd2;
                        open_next = OT_IDLE;
                        case (open_reg)
                            OT_EQ:   r0_kind = K_EQEQ;
                            OT_BANG: r0_kind = K_NE;
                            OT_LT:   r0_kind = K_LE;
                            default: r0_kind = K_GE;
                        endcase
                    end
                end
                OT_AMP:
                begin
                    if (c == CH_AMP)
                    begin
                        consumed  = 1'b1;
                        r0_valid  = 1'b1;
                        r0_kind   = K_ANDAND;
                        r0_len    = 16'd2;
                        open_next = OT_IDLE;
                    end
                end
                OT_BAR:
                begin
                    if (c == CH_BAR)
                    begin
                        consumed  = 1'b1;
                        r0_valid  = 1'b1;
                        r0_kind   = K_OROR;
                        r0_len    = 16'd2;
                        open_next = OT_IDLE;
                    end
                end
                default:
                begin
                    consumed = 1'b0;
                end
            endcase

            if (!consumed)
            begin
                r0_valid  = flush_valid;
                r0_kind   = flush_kind;
                r0_len    = flush_len;
                open_next = OT_IDLE;
                if (!is_space)
                begin
                    tok_line_next = cur_line_reg;
                    tok_col_next  = cur_col_reg;
                    tok_off_next  = cur_off_reg;
                    count_next    = 16'd0;
                    overlong_next = 1'b0;
                    if (is_alpha || c == CH_UNDER)
                    begin
                        open_next  = OT_IDENT;
                        store_we   = 1'b1;
                        store_idx  = '0;
                        count_next = 16'd1;
                    end
                    else if (is_digit)
                    begin
                        open_next  = OT_NUMBER;
                        count_next = 16'd1;
                    end
                    else
                    begin
                        case (c)
                            CH_QUOTE:  open_next = OT_STRING;
                            CH_EQ:     open_next = OT_EQ;
                            CH_BANG:   open_next = OT_BANG;
                            CH_LT:     open_next = OT_LT;
                            CH_GT:     open_next = OT_GT;
                            CH_AMP:    open_next = OT_AMP;
                            CH_BAR:    open_next = OT_BAR;
                            CH_PLUS:   r1_kind = K_PLUS;
                            CH_MINUS:  r1_kind = K_MINUS;
                            CH_STAR:   r1_kind = K_STAR;
                            CH_SLASH:  r1_kind = K_SLASH;
                            CH_LPAREN: r1_kind = K_LPAREN;
                            CH_RPAREN: r1_kind = K_RPAREN;
                            CH_LBRACE: r1_kind = K_LBRACE;
                            CH_RBRACE: r1_kind = K_RBRACE;
                            CH_SEMI:   r1_kind = K_SEMI;
                            CH_COMMA:  r1_kind = K_COMMA;
                            default:   r1_kind = K_UNKNOWN;
                        endcase
                        r1_valid = (open_next == OT_IDLE);
                    end
                end
            end

            if (c == CH_NL)
            begin
                if (cur_line_reg != POS_MAX)
                begin
                    cur_line_next = cur_line_reg + POS_ONE;
                end
                cur_col_next = POS_ONE;
            end
            else if (cur_col_reg != POS_MAX)
            begin
                cur_col_next = cur_col_reg + POS_ONE;
            end
            if (cur_off_reg != OFF_MAX)
            begin
                cur_off_next = cur_off_reg + OFFSET_BITS'(1);
            end
        end
    end

    always_comb
    begin
        r0.token_kind   = r0_kind;
        r0.first_line   = 16'(tok_line_reg);
        r0.first_column = 16'(tok_col_reg);
        r0.start_offset = 32'(tok_off_reg);
        r0.text_length  = r0_len;
        r0.last         = !r1_valid;
        r1.token_kind   = r1_kind;
        r1.first_line   = 16'(cur_line_reg);
        r1.first_column = 16'(cur_col_reg);
        r1.start_offset = 32'(cur_off_reg);
        r1.text_length  = r1_len;
        r1.last         = 1'b1;
        push.count      = step_valid ? {r0_valid && r1_valid, r0_valid ^ r1_valid} : 2'd0;
        push.first      = r0_valid ? r0 : r1;
        push.second     = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= OT_IDLE;
            overlong_reg <= 1'b0;
            count_reg    <= 16'd0;
            tok_line_reg <= POS_ONE;
            tok_col_reg  <= POS_ONE;
            tok_off_reg  <= '0;
            cur_line_reg <= POS_ONE;
            cur_col_reg  <= POS_ONE;
            cur_off_reg  <= '0;
        end
        else if (step_valid)
        begin
            open_reg     <= open_next;
            overlong_reg <= overlong_next;
            count_reg    <= count_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            tok_off_reg  <= tok_off_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            cur_off_reg  <= cur_off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_valid && !step.mode && store_we)
        begin
            word_reg[store_idx] <= c;
        end
    end

endmodule

// ===== rtl/st_token_fifo.sv =====
module st_token_fifo
    import st_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  st_push_t push,
    output logic     space_ok,
    output logic     token_valid,
    input  logic     token_ready,
    output token_t   token
);

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    token_t              mem_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                pop;

    assign token_valid = (count_reg != '0);
    assign token       = mem_reg[rd_ptr_reg];
    assign pop         = token_valid && token_ready;
    assign space_ok    = (count_reg <= CNT_BITS'(FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
    assign count_next  = count_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_BITS'(1)] <= push.second;
        end
    end

endmodule

// ===== rtl/source_tokenizer.sv =====
// Streaming tokenizer: one source byte per request on the char channel,
// tokens with start line, column, offset and text length on the token channel.
// A request with mode set marks end of input: any open token is flushed,
// then an end token (or an open-string token) closes the source, and all
// position state returns to line 1, column 1, offset 0 for the next source.
// A request yields zero, one or two tokens; last marks the final one.
// A token is presented on the token channel once the request completing it
// has passed the input register and then the token queue; a request waits in
// the input register while the queue lacks room for two entries.
// Throughput: one request per cycle while the token queue has room for two
// entries; a request that yields two tokens needs two queue reads, so the
// sustained rate is set by the one-token-per-cycle queue read.
// When the receiver stalls, the queue fills and char_ready drops once fewer
// than two free entries remain; no token is lost or repeated.
// Reset clears the position counters, the open token and the queue.
module source_tokenizer
    import st_pkg::*;
#(
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_ready,
    input  char_req_t char_req,
    output logic      token_valid,
    input  logic      token_ready,
    output token_t    token
);

    logic      req_valid_reg;
    char_req_t req_reg;
    logic      space_ok;
    logic      advance;
    st_push_t  push;

    assign advance    = req_valid_reg && space_ok;
    assign char_ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (char_ready)
        begin
            req_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
        begin
            req_reg <= char_req;
        end
    end

    st_lexer #(
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .POSITION_BITS (POSITION_BITS),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (advance),
        .step       (req_reg),
        .push       (push)
    );

    st_token_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .space_ok    (space_ok),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token       (token)
    );

endmodule

// ===== rtl/st_checker.sv =====
`include "source_tokenizer_macros.svh"

module st_checker
    import st_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      token_valid,
    input logic      token_ready,
    input token_t    token
);

    `ST_ASSERT_NEXT(a_token_hold, token_valid && !token_ready, token_valid && $stable(token), "token request changed while stalled")
    `ST_ASSERT_NOW(a_kind_range, token_valid, token.token_kind <= K_OPEN_STRING, "token kind out of range")
    `ST_ASSERT_NOW(a_end_last, token_valid && (token.token_kind == K_END || token.token_kind == K_OPEN_STRING), token.last && (token.token_kind != K_END || token.text_length == 16'd0), "end token not last or has length")
    `ST_ASSERT_NEXT(a_pair_follows, token_valid && token_ready && !token.last, token_valid, "second token of a pair missing")

endmodule

bind source_tokenizer st_checker u_st_checker (.*);
